/* hdl/bcpg_pkg.sv */
`default_nettype none
package bcpg_pkg;

	localparam int DEF_MAX_POINTS = 20;
	localparam int DEF_FRAC_BITS  = 24;
	localparam int COORD_W        = 16;
	// A coordinate times a 16-bit scale, divided by 256.
	localparam int SCALED_W       = 24;
	localparam logic [15:0] VIEW_SCALE_RESET = 16'd256;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_LEN_RD,
		ST_LEN_MUL,
		ST_LEN_ACC,
		ST_NORM,
		ST_STEP,
		ST_TERM,
		ST_MUL,
		ST_WB,
		ST_PROD,
		ST_ACC,
		ST_FIN
	} bcpg_state_t;

	typedef struct packed {
		logic load;
		logic scan_init;
		logic eval_init;
		logic len_mul;
		logic len_acc;
		logic norm;
		logic set_step;
		logic term_init;
		logic mul;
		logic wb;
		logic prod;
		logic acc;
		logic fin;
	} bcpg_cmd_t;

	typedef struct packed {
		logic active;
		logic len_last;
		logic norm_found;
		logic single_point;
		logic mul_last;
		logic term_last;
		logic out_busy;
	} bcpg_status_t;

endpackage
`default_nettype wire

/* hdl/bcpg_ctrl.sv */
`default_nettype none
module bcpg_ctrl (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   in_valid,
	input  wire                   func,
	input  wire                   last_point,
	input  bcpg_pkg::bcpg_status_t st,
	output logic                  in_ready,
	output bcpg_pkg::bcpg_cmd_t   cmd
);
	import bcpg_pkg::*;

	bcpg_state_t state_q;
	bcpg_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					if (!func && !st.active && last_point) begin
						state_d = ST_LEN_RD;
					end else if (func && st.active) begin
						state_d = ST_TERM;
					end
				end
			end
			ST_LEN_RD:  state_d = ST_LEN_MUL;
			ST_LEN_MUL: state_d = ST_LEN_ACC;
			ST_LEN_ACC: state_d = st.len_last ? ST_NORM : ST_LEN_RD;
			ST_NORM: begin
				if (st.norm_found) begin
					state_d = ST_STEP;
				end
			end
			ST_STEP: state_d = ST_IDLE;
			ST_TERM: state_d = st.single_point ? ST_WB : ST_MUL;
			ST_MUL: begin
				if (st.mul_last) begin
					state_d = ST_WB;
				end
			end
			ST_WB:   state_d = ST_PROD;
			ST_PROD: state_d = ST_ACC;
			ST_ACC:  state_d = st.term_last ? ST_FIN : ST_TERM;
			ST_FIN: begin
				if (!st.out_busy) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready = 1'b0;
		cmd      = '0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					if (!func && !st.active) begin
						cmd.load      = 1'b1;
						cmd.scan_init = last_point;
					end else if (func && st.active) begin
						cmd.eval_init = 1'b1;
					end
				end
			end
			ST_LEN_RD:  ;
			ST_LEN_MUL: cmd.len_mul   = 1'b1;
			ST_LEN_ACC: cmd.len_acc   = 1'b1;
			ST_NORM:    cmd.norm      = 1'b1;
			ST_STEP:    cmd.set_step  = 1'b1;
			ST_TERM:    cmd.term_init = 1'b1;
			ST_MUL:     cmd.mul       = 1'b1;
			ST_WB:      cmd.wb        = 1'b1;
			ST_PROD:    cmd.prod      = 1'b1;
			ST_ACC:     cmd.acc       = 1'b1;
			ST_FIN:     cmd.fin       = !st.out_busy;
			default:    ;
		endcase
	end

endmodule
`default_nettype wire

/* hdl/bcpg_dp.sv */
`default_nettype none
module bcpg_dp #(
	parameter int MAX_POINTS = bcpg_pkg::DEF_MAX_POINTS,
	parameter int FRAC_BITS  = bcpg_pkg::DEF_FRAC_BITS
) (
	input  wire                                clk,
	input  wire                                arst_n,
	input  wire                                cfg_we,
	input  wire  [15:0]                        cfg_wdata,
	input  wire  [bcpg_pkg::COORD_W-1:0]       point_x,
	input  wire  [bcpg_pkg::COORD_W-1:0]       point_y,
	input  bcpg_pkg::bcpg_cmd_t                cmd,
	input  wire                                out_ready,
	output bcpg_pkg::bcpg_status_t             st,
	output logic                               out_valid,
	output logic [bcpg_pkg::COORD_W-1:0]       pixel_x,
	output logic [bcpg_pkg::COORD_W-1:0]       pixel_y,
	output logic                               curve_done
);
	import bcpg_pkg::*;

	localparam int CW  = $clog2(MAX_POINTS + 1);
	localparam int AW  = $clog2(MAX_POINTS);
	localparam int TW  = FRAC_BITS + 1;
	localparam int BW  = MAX_POINTS;
	localparam int PW  = FRAC_BITS + COORD_W;
	localparam int EW  = (TW + BW > PW) ? TW + BW : PW;
	localparam int LW  = SCALED_W + $clog2(2 * MAX_POINTS);
	localparam int PSW = $clog2(LW);
	localparam int KW  = $clog2(LW + 1);
	localparam logic [TW-1:0] ONE     = TW'(1) << FRAC_BITS;
	localparam logic [TW-1:0] HALF    = TW'(1) << (FRAC_BITS - 1);
	localparam logic [TW-1:0] QUARTER = TW'(1) << (FRAC_BITS - 2);

	logic [COORD_W-1:0]  mem_x [MAX_POINTS];
	logic [COORD_W-1:0]  mem_y [MAX_POINTS];
	logic [COORD_W-1:0]  rd_x_q, rd_y_q;
	logic [15:0]         view_scale_q;
	logic [CW-1:0]       count_q, idx_q, m_q;
	logic                active_q;
	logic [TW-1:0]       t_q, step_q, w_q;
	logic [BW-1:0]       row_q [MAX_POINTS];
	logic [SCALED_W-1:0] scx_q, scy_q, prevx_q, prevy_q;
	logic [LW-1:0]       len_q;
	logic [PSW-1:0]      pos_q;
	logic [KW-1:0]       k_q;
	logic [PW-1:0]       wb_q, px_q, py_q, sx_q, sy_q;
	logic                out_valid_q, done_q;
	logic [COORD_W-1:0]  pix_x_q, pix_y_q;

	logic [31:0]         sc_x_full, sc_y_full;
	logic [TW-1:0]       mul_op, omt;
	logic [2*TW-1:0]     w_full;
	logic [EW-1:0]       wb_full;
	logic [CW-1:0]       n_m1, n_m1_i;
	logic                len_small, pos_bit_lo;
	logic [PSW-1:0]      pos_m1;
	logic [TW-1:0]       step_raw;
	logic [TW:0]         t_inc, t_next;
	logic                t_done;

	assign omt       = ONE - t_q;
	assign n_m1      = count_q - CW'(1);
	assign n_m1_i    = n_m1 - idx_q;
	assign mul_op    = (m_q < n_m1_i) ? omt : t_q;
	assign w_full    = (2*TW)'(w_q) * (2*TW)'(mul_op);
	assign wb_full   = EW'(w_q) * EW'(row_q[idx_q[AW-1:0]]);
	assign sc_x_full = 32'(rd_x_q) * 32'(view_scale_q);
	assign sc_y_full = 32'(rd_y_q) * 32'(view_scale_q);
	assign len_small = len_q <= LW'(1);
	assign pos_m1    = pos_q - PSW'(1);
	assign pos_bit_lo = (pos_q == '0) ? 1'b0 : len_q[pos_m1];
	assign step_raw  = HALF >> k_q;
	assign t_inc     = (t_q > QUARTER) ? {step_q, 1'b0} : {1'b0, step_q};
	assign t_next    = {1'b0, t_q} + t_inc;
	assign t_done    = t_next >= {1'b0, ONE};

	always_comb begin
		st              = '0;
		st.active       = active_q;
		st.len_last     = (idx_q + CW'(1)) == count_q;
		st.norm_found   = len_small || len_q[pos_q];
		st.single_point = count_q == CW'(1);
		st.mul_last     = (m_q + CW'(1)) == n_m1;
		st.term_last    = (idx_q + CW'(1)) == count_q;
		st.out_busy     = out_valid_q && !out_ready;
	end

	// Control point store: one write port, one registered read port.
	always_ff @(posedge clk) begin
		if (cmd.load && count_q < CW'(MAX_POINTS)) begin
			mem_x[count_q[AW-1:0]] <= point_x;
			mem_y[count_q[AW-1:0]] <= point_y;
		end
		rd_x_q <= mem_x[idx_q[AW-1:0]];
		rd_y_q <= mem_y[idx_q[AW-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			view_scale_q <= VIEW_SCALE_RESET;
			count_q      <= '0;
			active_q     <= 1'b0;
			t_q          <= '0;
			step_q       <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_we) begin
				view_scale_q <= cfg_wdata;
			end
			if (cmd.load && count_q < CW'(MAX_POINTS)) begin
				count_q <= count_q + CW'(1);
			end
			if (cmd.set_step) begin
				step_q   <= (step_raw == '0) ? TW'(1) : step_raw;
				t_q      <= '0;
				active_q <= 1'b1;
			end
			if (cmd.fin) begin
				if (t_done) begin
					active_q <= 1'b0;
					count_q  <= '0;
					t_q      <= '0;
				end else begin
					t_q <= t_next[TW-1:0];
				end
			end
			if (cmd.fin) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.scan_init || cmd.eval_init) begin
			idx_q <= '0;
		end else if (cmd.len_acc || cmd.acc) begin
			idx_q <= idx_q + CW'(1);
		end
		if (cmd.scan_init) begin
			len_q <= '0;
			pos_q <= PSW'(LW - 1);
			for (int j = 0; j < MAX_POINTS; j++) begin
				row_q[j] <= (j == 0) ? BW'(1) : '0;
			end
		end
		if (cmd.len_mul) begin
			scx_q <= sc_x_full[31:8];
			scy_q <= sc_y_full[31:8];
		end
		if (cmd.len_acc) begin
			prevx_q <= scx_q;
			prevy_q <= scy_q;
			if (idx_q != '0) begin
				len_q <= len_q + LW'(scx_q ^ prevx_q) + LW'(scy_q ^ prevy_q);
				// One step down Pascal's triangle per neighbouring pair.
				for (int j = 1; j < MAX_POINTS; j++) begin
					row_q[j] <= row_q[j] + row_q[j-1];
				end
			end
		end
		if (cmd.norm) begin
			if (len_small) begin
				k_q <= '0;
			end else if (len_q[pos_q]) begin
				k_q <= KW'(pos_q) + KW'(pos_bit_lo);
			end else begin
				pos_q <= pos_m1;
			end
		end
		if (cmd.eval_init) begin
			sx_q <= '0;
			sy_q <= '0;
		end
		if (cmd.term_init) begin
			w_q <= ONE;
			m_q <= '0;
		end
		if (cmd.mul) begin
			w_q <= w_full[FRAC_BITS +: TW];
			m_q <= m_q + CW'(1);
		end
		if (cmd.wb) begin
			wb_q <= wb_full[PW-1:0];
		end
		if (cmd.prod) begin
			px_q <= PW'(rd_x_q) * wb_q;
			py_q <= PW'(rd_y_q) * wb_q;
		end
		if (cmd.acc) begin
			sx_q <= sx_q + px_q;
			sy_q <= sy_q + py_q;
		end
		if (cmd.fin) begin
			pix_x_q <= sx_q[FRAC_BITS +: COORD_W];
			pix_y_q <= sy_q[FRAC_BITS +: COORD_W];
			done_q  <= t_done;
		end
	end

	assign out_valid  = out_valid_q;
	assign pixel_x    = pix_x_q;
	assign pixel_y    = pix_y_q;
	assign curve_done = done_q;

endmodule
`default_nettype wire

/* hdl/bezier_curve_point_generator.sv */
// Bezier curve point generator.
// Requests arrive on the s_axis channel. tuser selects the kind: 0 loads a
// control point (tdata holds x then y), 1 is a tick asking for the next curve
// point. tlast on a load closes the control point list and starts a curve.
// Each tick while a curve is active gives one result on m_axis: the point in
// tdata (x then y) and tlast on the final point of the curve. Other requests
// give no result.
// The closing load holds the input while the length estimate is built from
// the point store, with a read, a multiply and an accumulate step for each
// point, and its leading bit is found one bit a cycle. For n control points
// every Bernstein weight of a tick is built by n-1 passes through one shared
// fractional multiplier, then scaled by its binomial coefficient and by both
// coordinates. A result waits in the output register while the receiver
// stalls; loads and ticks are still taken, and a tick holds in its last cycle
// until the register is free. After reset the point list is empty, no curve
// is active and view_scale is 256. view_scale is written through cfg_we, and
// the user must do so only while the block is idle; the block itself does not
// enforce it.
`default_nettype none
module bezier_curve_point_generator #(
	parameter int MAX_POINTS = bcpg_pkg::DEF_MAX_POINTS,
	parameter int FRAC_BITS  = bcpg_pkg::DEF_FRAC_BITS
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         cfg_we,
	input  wire  [15:0] cfg_wdata,     // view_scale
	input  wire         s_axis_tvalid,
	output logic        s_axis_tready,
	input  wire  [31:0] s_axis_tdata,  // point_x [15:0], point_y [31:16]
	input  wire         s_axis_tuser,  // func
	input  wire         s_axis_tlast,  // last_point
	output logic        m_axis_tvalid,
	input  wire         m_axis_tready,
	output logic [31:0] m_axis_tdata,  // pixel_x [15:0], pixel_y [31:16]
	output logic        m_axis_tlast   // curve_done
);
	import bcpg_pkg::*;

	bcpg_cmd_t          cmd;
	bcpg_status_t       st;
	logic [COORD_W-1:0] pixel_x, pixel_y;

	bcpg_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_axis_tvalid),
		.func       (s_axis_tuser),
		.last_point (s_axis_tlast),
		.st         (st),
		.in_ready   (s_axis_tready),
		.cmd        (cmd)
	);

	bcpg_dp #(
		.MAX_POINTS (MAX_POINTS),
		.FRAC_BITS  (FRAC_BITS)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.point_x    (s_axis_tdata[15:0]),
		.point_y    (s_axis_tdata[31:16]),
		.cmd        (cmd),
		.out_ready  (m_axis_tready),
		.st         (st),
		.out_valid  (m_axis_tvalid),
		.pixel_x    (pixel_x),
		.pixel_y    (pixel_y),
		.curve_done (m_axis_tlast)
	);

	assign m_axis_tdata = {pixel_y, pixel_x};

	// A new result must never overwrite one still waiting for the receiver.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.fin |-> !(m_axis_tvalid && !m_axis_tready))
		else $error("result register overwritten");

	// The final point of a curve leaves the block with no curve active, and any other point leaves it active.
	a_done_inactive: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.fin |=> (m_axis_tvalid && (m_axis_tlast != st.active)))
		else $error("curve still active after final point");

	// Points are only stored between curves.
	a_load_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |-> !st.active)
		else $error("point stored during a curve");

endmodule
`default_nettype wire

/* tb/sv/tb_bezier_curve_point_generator.sv */
`default_nettype none
module tb_bezier_curve_point_generator;
	import bcpg_pkg::*;

	localparam int NPTS = DEF_MAX_POINTS;
	localparam int FB = DEF_FRAC_BITS;
	localparam logic [63:0] ONE_Q = 64'd1 << FB;
	localparam logic FUNC_LOAD = 1'b0;
	localparam logic FUNC_TICK = 1'b1;
	localparam int ITEM_TARGET = 1950;
	localparam int IDLE_LIMIT = 5000;
	localparam int SETTLE = 600;

	typedef struct packed {
		logic [15:0] px;
		logic [15:0] py;
		logic done;
	} pixel_t;

	typedef struct {
		logic func;
		logic [15:0] x;
		logic [15:0] y;
		logic last;
		bit typed;
		pixel_t want;
	} stim_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [15:0] cfg_wdata = '0;
	logic s_axis_tvalid = 1'b0;
	wire s_axis_tready;
	logic [31:0] s_axis_tdata = '0;
	logic s_axis_tuser = 1'b0;
	logic s_axis_tlast = 1'b0;
	wire m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	wire [31:0] m_axis_tdata;
	wire m_axis_tlast;

	bezier_curve_point_generator uut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
		.s_axis_tlast(s_axis_tlast), .m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata),
		.m_axis_tlast(m_axis_tlast)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Mirror of the block state.
	logic [15:0] mx [NPTS];
	logic [15:0] my [NPTS];
	int pt_count;
	logic [63:0] t_now, step_q;
	bit active;
	logic [15:0] scale;

	pixel_t pixel_q[$];
	int errors, items, requests, results, curves, idle_cycles;
	bit quiet;

	task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
		$display("mismatch %s: got %0h, expected %0h at %0t", what, got, want, $time);
		errors++;
	endtask

	function automatic logic [63:0] qmul(input logic [63:0] a, input logic [63:0] b);
		if (a >= ONE_Q) return b;
		if (b >= ONE_Q) return a;
		return (a * b) >> FB;
	endfunction

	function automatic logic [63:0] path_length(input logic [15:0] xs [NPTS],
			input logic [15:0] ys [NPTS], input int n, input logic [15:0] sc);
		logic [63:0] tot;
		tot = 0;
		for (int i = 0; i + 1 < n; i++) begin
			tot += ((64'(xs[i]) * sc) / 256) ^ ((64'(xs[i + 1]) * sc) / 256);
			tot += ((64'(ys[i]) * sc) / 256) ^ ((64'(ys[i + 1]) * sc) / 256);
		end
		return tot;
	endfunction

	function automatic logic [63:0] step_for(input logic [63:0] len);
		int h, k;
		logic [63:0] s;
		k = 0;
		if (len > 1) begin
			h = 0;
			while (h < 63 && (len >> (h + 1)) != 0) h++;
			k = len[h - 1] ? h + 1 : h;
		end
		s = (ONE_Q >> 1) >> (k > 62 ? 62 : k);
		return (s == 0) ? 64'd1 : s;
	endfunction

	// Number of points a curve with this base step produces, capped.
	function automatic int points_for(input logic [63:0] s, input int cap);
		logic [63:0] t, nx;
		int c;
		t = 0;
		c = 0;
		forever begin
			c++;
			nx = t + ((t > (ONE_Q >> 2)) ? s * 2 : s);
			if (nx >= ONE_Q || c > cap) return c;
			t = nx;
		end
	endfunction

	function automatic bit curve_point(input logic func, input logic [15:0] x,
			input logic [15:0] y, input logic last, output pixel_t r);
		logic [63:0] omt, binom, w, sx, sy, nx;
		r = '0;
		if (func == FUNC_LOAD) begin
			if (active) return 0;
			if (pt_count < NPTS) begin
				mx[pt_count] = x;
				my[pt_count] = y;
				pt_count++;
			end
			if (last) begin
				step_q = step_for(path_length(mx, my, pt_count, scale));
				t_now = 0;
				active = 1;
			end
			return 0;
		end
		if (!active) return 0;
		omt = ONE_Q - t_now;
		binom = 1;
		sx = 0;
		sy = 0;
		for (int i = 0; i < pt_count; i++) begin
			if (i > 0) binom = binom * (pt_count - i) / i;
			w = ONE_Q;
			for (int j = 0; j + i + 1 < pt_count; j++) w = qmul(w, omt);
			for (int j = 0; j < i; j++) w = qmul(w, t_now);
			w *= binom;
			sx += 64'(mx[i]) * w;
			sy += 64'(my[i]) * w;
		end
		nx = t_now + ((t_now > (ONE_Q >> 2)) ? step_q * 2 : step_q);
		r.px = sx[FB +: 16];
		r.py = sy[FB +: 16];
		r.done = (nx >= ONE_Q);
		if (r.done) begin
			active = 0;
			pt_count = 0;
			t_now = 0;
		end else begin
			t_now = nx;
		end
		return 1;
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (quiet || r < 70) return 0;
		if (r < 97) return $urandom_range(1, 3);
		return $urandom_range(20, 60);
	endfunction

	task automatic send(input logic func, input logic [15:0] x, input logic [15:0] y,
			input logic last, input bit typed, input pixel_t want);
		int gap;
		pixel_t r;
		gap = pick_gap();
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {y, x};
		s_axis_tuser <= func;
		s_axis_tlast <= last;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		requests++;
		if (curve_point(func, x, y, last, r)) pixel_q.push_back(typed ? want : r);
		@(negedge clk);
	endtask

	task automatic drain();
		s_axis_tvalid <= 1'b0;
		while (pixel_q.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic set_scale(input logic [15:0] v);
		drain();
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_we <= 1'b0;
		scale = v;
	endtask

	// Loads a list then ticks it to its end, with ignored requests mixed in.
	task automatic run_curve(input logic [15:0] xs [24], input logic [15:0] ys [24],
			input int n);
		if ($urandom_range(0, 19) == 0)
			send(FUNC_TICK, 16'($urandom), 16'($urandom), 1'($urandom), 1'b0, '0);
		for (int i = 0; i < n; i++) send(FUNC_LOAD, xs[i], ys[i], i == n - 1, 1'b0, '0);
		curves++;
		items += n;
		while (active) begin
			if ($urandom_range(0, 19) == 0)
				send(FUNC_LOAD, 16'($urandom), 16'($urandom), 1'($urandom), 1'b0, '0);
			send(FUNC_TICK, 16'($urandom), 16'($urandom), 1'($urandom), 1'b0, '0);
			items++;
		end
	endtask

	task automatic random_curve(input int n);
		logic [15:0] xs [24];
		logic [15:0] ys [24];
		logic [15:0] cx [NPTS];
		logic [15:0] cy [NPTS];
		logic [15:0] bx, by, mask;
		int cap, m;
		bit ok;
		cap = (n > 8) ? 8 : 40;
		m = (n > NPTS) ? NPTS : n;
		ok = 0;
		bx = 16'($urandom);
		by = 16'($urandom);
		for (int tries = 0; tries < 8 && !ok; tries++) begin
			mask = 16'((1 << $urandom_range(0, 3)) - 1);
			for (int i = 0; i < n; i++) begin
				xs[i] = bx ^ (16'($urandom) & mask);
				ys[i] = by ^ (16'($urandom) & mask);
				if (i < NPTS) begin
					cx[i] = xs[i];
					cy[i] = ys[i];
				end
			end
			ok = points_for(step_for(path_length(cx, cy, m, scale)), cap) <= cap;
		end
		if (!ok) begin
			for (int i = 0; i < n; i++) begin
				xs[i] = bx;
				ys[i] = by;
			end
		end
		run_curve(xs, ys, n);
	endtask

	always @(posedge clk) begin
		pixel_t w;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			results++;
			if (pixel_q.size() == 0) begin
				report("unexpected result", {m_axis_tdata[31:0]}, 32'h0);
			end else begin
				w = pixel_q.pop_front();
				if (m_axis_tdata[15:0] !== w.px) report("pixel_x", m_axis_tdata[15:0], w.px);
				if (m_axis_tdata[31:16] !== w.py) report("pixel_y", m_axis_tdata[31:16], w.py);
				if (m_axis_tlast !== w.done) report("curve_done", m_axis_tlast, w.done);
			end
		end
	end

	// Receiver stalls: mostly short, now and then long, none in quiet stretches.
	int stall_left = 0;
	always @(negedge clk) begin
		int r;
		r = $urandom_range(0, 99);
		if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			m_axis_tready <= 1'b0;
		end else if (!quiet && r < 20) begin
			stall_left <= (r < 2) ? $urandom_range(30, 60) : $urandom_range(0, 3);
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	stim_row_t rows [] = '{
		'{FUNC_TICK, 16'h1234, 16'h5678, 1'b0, 1'b0, '0},
		'{FUNC_LOAD, 16'hFFFF, 16'hFFFF, 1'b0, 1'b0, '0},
		'{FUNC_LOAD, 16'hFFFF, 16'hFFFF, 1'b1, 1'b0, '0},
		'{FUNC_LOAD, 16'h1234, 16'h4321, 1'b1, 1'b0, '0},
		'{FUNC_TICK, 16'h0000, 16'h0000, 1'b0, 1'b1, '{16'hFFFF, 16'hFFFF, 1'b0}},
		'{FUNC_TICK, 16'hFFFF, 16'hFFFF, 1'b1, 1'b1, '{16'hFFFF, 16'hFFFF, 1'b1}},
		'{FUNC_TICK, 16'h0000, 16'h0000, 1'b0, 1'b0, '0},
		'{FUNC_LOAD, 16'h0000, 16'h0000, 1'b0, 1'b0, '0},
		'{FUNC_LOAD, 16'h0000, 16'h0000, 1'b1, 1'b0, '0},
		'{FUNC_TICK, 16'h0000, 16'h0000, 1'b0, 1'b1, '{16'h0000, 16'h0000, 1'b0}},
		'{FUNC_TICK, 16'h0000, 16'h0000, 1'b0, 1'b1, '{16'h0000, 16'h0000, 1'b1}},
		'{FUNC_LOAD, 16'hABCD, 16'h1234, 1'b1, 1'b0, '0},
		'{FUNC_TICK, 16'h0000, 16'h0000, 1'b0, 1'b1, '{16'hABCD, 16'h1234, 1'b0}},
		'{FUNC_TICK, 16'h0000, 16'h0000, 1'b0, 1'b1, '{16'hABCD, 16'h1234, 1'b1}},
		'{FUNC_LOAD, 16'h0000, 16'h0000, 1'b0, 1'b0, '0},
		'{FUNC_LOAD, 16'h0010, 16'h0020, 1'b0, 1'b0, '0},
		'{FUNC_LOAD, 16'h0003, 16'h0007, 1'b1, 1'b0, '0},
		'{FUNC_TICK, 16'h0000, 16'h0000, 1'b0, 1'b0, '0},
		'{FUNC_TICK, 16'h0000, 16'h0000, 1'b0, 1'b0, '0},
		'{FUNC_TICK, 16'h0000, 16'h0000, 1'b0, 1'b0, '0}
	};

	logic [15:0] scale_plan [] = '{16'd0, 16'd65535, 16'd1, 16'd128, 16'd256, 16'd777};

	initial begin
		logic [15:0] xs [24];
		logic [15:0] ys [24];
		int phase;
		errors = 0;
		items = 0;
		requests = 0;
		results = 0;
		curves = 0;
		idle_cycles = 0;
		quiet = 0;
		pt_count = 0;
		t_now = 0;
		step_q = 0;
		active = 0;
		scale = VIEW_SCALE_RESET;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (rows[i]) begin
			send(rows[i].func, rows[i].x, rows[i].y, rows[i].last, rows[i].typed, rows[i].want);
			items++;
		end
		while (active) begin
			send(FUNC_TICK, 16'h0, 16'h0, 1'b0, 1'b0, '0);
			items++;
		end

		// A longer curve, and a list that overflows the point store.
		for (int i = 0; i < 24; i++) begin
			xs[i] = 16'h0;
			ys[i] = 16'h0;
		end
		xs[1] = 16'h0100;
		run_curve(xs, ys, 2);
		random_curve(NPTS + 2);

		phase = 0;
		while (items < ITEM_TARGET) begin
			if ((curves % 12) == 0) begin
				set_scale(scale_plan[phase % scale_plan.size()]);
				quiet = (phase % 3) == 2;
				phase++;
			end
			if (curves == 40) begin
				s_axis_tvalid <= 1'b0;
				while (pixel_q.size() != 0) @(posedge clk);
				@(negedge clk);
			end
			random_curve(($urandom_range(0, 15) == 0) ? $urandom_range(9, NPTS + 3)
				: $urandom_range(1, 6));
		end
		drain();

		$display("%0d requests, %0d curves, %0d curve points over %0d scale settings;",
			requests, curves, results, phase + 1);
		$display("lists up to overflow, ignored loads and ticks, sender and receiver stalls.");
		if (errors == 0 && pixel_q.size() == 0) begin
			$display("CHECK OK");
		end else begin
			if (pixel_q.size() != 0) report("results left waiting", pixel_q.size(), 0);
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule
`default_nettype wire
